>>> rtl/ldgx_pkg.sv
// Shared types, opcodes, register codes and register-file helpers for the
// 8-bit load group executor. No dependencies.
package ldgx_pkg;

	// Memory geometry
	localparam int          ADDR_BITS_DEF = 16;
	localparam logic [15:0] HIGH_PAGE     = 16'hFF00;

	// Register operand codes as encoded in opcode bits [5:3] and [2:0]
	localparam logic [2:0] CODE_B   = 3'd0;
	localparam logic [2:0] CODE_C   = 3'd1;
	localparam logic [2:0] CODE_D   = 3'd2;
	localparam logic [2:0] CODE_E   = 3'd3;
	localparam logic [2:0] CODE_H   = 3'd4;
	localparam logic [2:0] CODE_L   = 3'd5;
	localparam logic [2:0] CODE_MEM = 3'd6;
	localparam logic [2:0] CODE_A   = 3'd7;

	// Opcodes
	localparam logic [7:0] OP_REG_FIRST = 8'h40;
	localparam logic [7:0] OP_REG_LAST  = 8'h7F;
	localparam logic [7:0] OP_HALT      = 8'h76;
	localparam logic [7:0] OP_LD_BC_A   = 8'h02;
	localparam logic [7:0] OP_LD_DE_A   = 8'h12;
	localparam logic [7:0] OP_LD_HLI_A  = 8'h22;
	localparam logic [7:0] OP_LD_HLD_A  = 8'h32;
	localparam logic [7:0] OP_LD_A_BC   = 8'h0A;
	localparam logic [7:0] OP_LD_A_DE   = 8'h1A;
	localparam logic [7:0] OP_LD_A_HLI  = 8'h2A;
	localparam logic [7:0] OP_LD_A_HLD  = 8'h3A;
	localparam logic [7:0] OP_LD_B_N    = 8'h06;
	localparam logic [7:0] OP_LD_D_N    = 8'h16;
	localparam logic [7:0] OP_LD_H_N    = 8'h26;
	localparam logic [7:0] OP_LD_HL_N   = 8'h36;
	localparam logic [7:0] OP_LDH_N_A   = 8'hE0;
	localparam logic [7:0] OP_LDH_A_N   = 8'hF0;
	localparam logic [7:0] OP_LDH_C_A   = 8'hE2;
	localparam logic [7:0] OP_LDH_A_C   = 8'hF2;
	localparam logic [7:0] OP_LD_NN_A   = 8'hEA;
	localparam logic [7:0] OP_LD_A_NN   = 8'hFA;

	// Architectural byte registers
	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] d;
		logic [7:0] e;
		logic [7:0] h;
		logic [7:0] l;
	} regs_t;

	// Decoded instruction
	typedef struct packed {
		logic        unsup;
		logic [1:0]  len;
		logic [4:0]  clocks;
		logic        mem_rd;
		logic        mem_wr;
		logic [15:0] addr;
		logic [7:0]  wdata;
		logic [2:0]  ld_code;
		logic        wr_en;
		logic [2:0]  wr_code;
		logic [7:0]  wr_val;
		logic        hl_en;
		logic [15:0] hl_val;
	} dec_t;

	// Read a register by operand code; the memory code reads as zero
	function automatic logic [7:0] get_reg(regs_t r, logic [2:0] code);
		logic [7:0] v;
		case (code)
			CODE_B:  v = r.b;
			CODE_C:  v = r.c;
			CODE_D:  v = r.d;
			CODE_E:  v = r.e;
			CODE_H:  v = r.h;
			CODE_L:  v = r.l;
			CODE_A:  v = r.a;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// Write a register by operand code; the memory code changes nothing
	function automatic regs_t put_reg(regs_t r, logic [2:0] code, logic [7:0] v);
		regs_t res;
		res = r;
		case (code)
			CODE_B:  res.b = v;
			CODE_C:  res.c = v;
			CODE_D:  res.d = v;
			CODE_E:  res.e = v;
			CODE_H:  res.h = v;
			CODE_L:  res.l = v;
			CODE_A:  res.a = v;
			default: res = r;
		endcase
		return res;
	endfunction

endpackage

>>> rtl/ldgx_if.sv
// Valid/ready channel interfaces for the load group executor: opcode words
// in, result words out. No dependencies.
interface ldgx_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] command;
	logic [7:0] imm_low;
	logic [7:0] imm_high;

	modport source (output valid, command, imm_low, imm_high, input ready);
	modport sink   (input valid, command, imm_low, imm_high, output ready);
endinterface

interface ldgx_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reg_a;
	logic [7:0]  reg_b;
	logic [7:0]  reg_c;
	logic [7:0]  reg_d;
	logic [7:0]  reg_e;
	logic [7:0]  reg_h;
	logic [7:0]  reg_l;
	logic [1:0]  length_bytes;
	logic [4:0]  clock_count;
	logic        unsupported;
	logic [15:0] mem_addr;
	logic [7:0]  mem_data;

	modport source (output valid, reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l,
		length_bytes, clock_count, unsupported, mem_addr, mem_data, input ready);
	modport sink   (input valid, reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l,
		length_bytes, clock_count, unsupported, mem_addr, mem_data, output ready);
endinterface

>>> rtl/ldgx_decode.sv
// Opcode decoder: turns an opcode word plus the current registers into the
// memory access and register updates it implies. Depends on ldgx_pkg.
module ldgx_decode import ldgx_pkg::*; (
	input  logic [7:0] command,
	input  logic [7:0] imm_low,
	input  logic [7:0] imm_high,
	input  regs_t      regs,
	output dec_t       dec
);

	logic [15:0] hl;
	logic [15:0] bc;
	logic [15:0] de;
	logic [15:0] nn;
	logic [2:0]  dst;
	logic [2:0]  src;

	assign hl  = {regs.h, regs.l};
	assign bc  = {regs.b, regs.c};
	assign de  = {regs.d, regs.e};
	assign nn  = {imm_high, imm_low};
	assign dst = command[5:3];
	assign src = command[2:0];

	// Decode; fields of no access stay zero
	always_comb begin
		dec = '0;
		if ((command inside {[OP_REG_FIRST:OP_REG_LAST]}) && command != OP_HALT) begin
			dec.len    = 2'd1;
			dec.clocks = (dst == CODE_MEM || src == CODE_MEM) ? 5'd8 : 5'd4;
			if (src == CODE_MEM) begin
				dec.mem_rd  = 1'b1;
				dec.addr    = hl;
				dec.ld_code = dst;
			end else if (dst == CODE_MEM) begin
				dec.mem_wr = 1'b1;
				dec.addr   = hl;
				dec.wdata  = get_reg(regs, src);
			end else begin
				dec.wr_en   = 1'b1;
				dec.wr_code = dst;
				dec.wr_val  = get_reg(regs, src);
			end
		end else begin
			case (command)
				OP_LD_BC_A, OP_LD_DE_A, OP_LD_HLI_A, OP_LD_HLD_A: begin
					dec.len    = 2'd1;
					dec.clocks = 5'd8;
					dec.mem_wr = 1'b1;
					dec.wdata  = regs.a;
					dec.addr   = (command == OP_LD_BC_A) ? bc :
						(command == OP_LD_DE_A) ? de : hl;
					dec.hl_en  = (command == OP_LD_HLI_A) || (command == OP_LD_HLD_A);
					dec.hl_val = (command == OP_LD_HLI_A) ? hl + 16'd1 : hl - 16'd1;
				end
				OP_LD_A_BC, OP_LD_A_DE, OP_LD_A_HLI, OP_LD_A_HLD: begin
					dec.len     = 2'd1;
					dec.clocks  = 5'd8;
					dec.mem_rd  = 1'b1;
					dec.ld_code = CODE_A;
					dec.addr    = (command == OP_LD_A_BC) ? bc :
						(command == OP_LD_A_DE) ? de : hl;
					dec.hl_en   = (command == OP_LD_A_HLI) || (command == OP_LD_A_HLD);
					dec.hl_val  = (command == OP_LD_A_HLI) ? hl + 16'd1 : hl - 16'd1;
				end
				OP_LD_B_N, OP_LD_D_N, OP_LD_H_N: begin
					dec.len     = 2'd2;
					dec.clocks  = 5'd8;
					dec.wr_en   = 1'b1;
					dec.wr_code = dst;
					dec.wr_val  = imm_low;
				end
				OP_LD_HL_N: begin
					dec.len    = 2'd2;
					dec.clocks = 5'd12;
					dec.mem_wr = 1'b1;
					dec.addr   = hl;
					dec.wdata  = imm_low;
				end
				OP_LDH_N_A: begin
					dec.len    = 2'd2;
					dec.clocks = 5'd12;
					dec.mem_wr = 1'b1;
					dec.addr   = HIGH_PAGE + {8'h00, imm_low};
					dec.wdata  = regs.a;
				end
				OP_LDH_A_N: begin
					dec.len     = 2'd2;
					dec.clocks  = 5'd12;
					dec.mem_rd  = 1'b1;
					dec.addr    = HIGH_PAGE + {8'h00, imm_low};
					dec.ld_code = CODE_A;
				end
				OP_LDH_C_A: begin
					dec.len    = 2'd1;
					dec.clocks = 5'd8;
					dec.mem_wr = 1'b1;
					dec.addr   = HIGH_PAGE + {8'h00, regs.c};
					dec.wdata  = regs.a;
				end
				OP_LDH_A_C: begin
					dec.len     = 2'd1;
					dec.clocks  = 5'd8;
					dec.mem_rd  = 1'b1;
					dec.addr    = HIGH_PAGE + {8'h00, regs.c};
					dec.ld_code = CODE_A;
				end
				OP_LD_NN_A: begin
					dec.len    = 2'd3;
					dec.clocks = 5'd16;
					dec.mem_wr = 1'b1;
					dec.addr   = nn;
					dec.wdata  = regs.a;
				end
				OP_LD_A_NN: begin
					dec.len     = 2'd3;
					dec.clocks  = 5'd16;
					dec.mem_rd  = 1'b1;
					dec.addr    = nn;
					dec.ld_code = CODE_A;
				end
				default: begin
					dec.unsup = 1'b1;
				end
			endcase
		end
	end

endmodule

>>> rtl/ldgx_mem.sv
// Data memory: one synchronous access port, registered read data that holds
// until the next read. Depends on ldgx_pkg for the default depth.
module ldgx_mem import ldgx_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] addr,
	input  logic [7:0]           wdata,
	output logic [7:0]           rdata
);

	logic [7:0] mem [2**ADDR_BITS];
	logic [7:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

	// Read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/cpu_8bit_load_group_executor_core.sv
// Top level of the 8-bit load group executor: decode, data memory, register
// file and result register. Depends on ldgx_pkg, ldgx_if, ldgx_decode, ldgx_mem.
//
// Usage:
//   cmd carries one opcode word (opcode plus up to two operand bytes). res
//   returns one word per opcode: all seven registers after it, its length and
//   clock count, an unsupported flag and the memory address and byte touched.
//   An accepted opcode waits in stage 1 and then enters the result register,
//   where its word becomes valid, when the result register is free.
//   Throughput: one opcode per cycle while res.ready is high, except after
//   an opcode that reads memory, which holds cmd.ready low until it leaves
//   stage 1 so that the loaded byte reaches the register file before the next
//   opcode reads it. The limit is the data memory port's registered read data.
//   Stores and register moves update state at the accept edge; the memory
//   is read there too and its byte merges when stage 1 advances.
//   Reset clears A, B, C, D, E, H, L and empties the pipeline; memory
//   contents are undefined until written.
//   When res.ready is low the result word holds; one more opcode may sit in
//   the stage behind it, after which cmd.ready drops.
module cpu_8bit_load_group_executor_core import ldgx_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ldgx_cmd_if.sink  cmd,
	ldgx_res_if.source res
);

	dec_t        dec;
	regs_t       regs_q;
	regs_t       regs_nx;
	regs_t       regs_view;
	logic        in_acc;
	logic        adv;
	logic        ld_done;
	logic [7:0]  mem_rdata;

	logic        valid_s1;
	logic        rd_s1;
	logic [2:0]  ld_code_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;
	logic [1:0]  len_s1;
	logic [4:0]  clocks_s1;
	logic        unsup_s1;

	logic        out_valid_q;
	regs_t       out_regs_q;
	logic [1:0]  out_len_q;
	logic [4:0]  out_clocks_q;
	logic        out_unsup_q;
	logic [15:0] out_addr_q;
	logic [7:0]  out_data_q;

	// Decode against the current register file
	ldgx_decode u_decode (
		.command  (cmd.command),
		.imm_low  (cmd.imm_low),
		.imm_high (cmd.imm_high),
		.regs     (regs_q),
		.dec      (dec)
	);

	// Handshake: stage 1 advances when the result register is free; interlock behind a memory read in flight
	assign adv       = valid_s1 && (!out_valid_q || res.ready);
	assign cmd.ready = (!valid_s1 || adv) && !(valid_s1 && rd_s1);
	assign in_acc    = cmd.valid && cmd.ready;
	assign ld_done   = adv && rd_s1;

	// Data memory
	ldgx_mem #(
		.ADDR_BITS (ADDR_BITS)
	) u_mem (
		.clk   (clk),
		.rd_en (in_acc && dec.mem_rd),
		.wr_en (in_acc && dec.mem_wr),
		.addr  (dec.addr[ADDR_BITS-1:0]),
		.wdata (dec.wdata),
		.rdata (mem_rdata)
	);

	// Register file next state
	always_comb begin
		regs_nx = regs_q;
		if (in_acc) begin
			if (dec.wr_en) begin
				regs_nx = put_reg(regs_nx, dec.wr_code, dec.wr_val);
			end
			if (dec.hl_en) begin
				regs_nx.h = dec.hl_val[15:8];
				regs_nx.l = dec.hl_val[7:0];
			end
		end
		if (ld_done) begin
			regs_nx = put_reg(regs_nx, ld_code_s1, mem_rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else begin
			regs_q <= regs_nx;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rd_s1    <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			rd_s1    <= dec.mem_rd;
		end else if (adv) begin
			valid_s1 <= 1'b0;
			rd_s1    <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ld_code_s1 <= dec.ld_code;
			addr_s1    <= dec.addr;
			wdata_s1   <= dec.wdata;
			len_s1     <= dec.len;
			clocks_s1  <= dec.clocks;
			unsup_s1   <= dec.unsup;
		end
	end

	// Registers as seen after the stage 1 opcode, loaded byte merged
	always_comb begin
		regs_view = regs_q;
		if (rd_s1) begin
			regs_view = put_reg(regs_q, ld_code_s1, mem_rdata);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_regs_q   <= regs_view;
			out_len_q    <= len_s1;
			out_clocks_q <= clocks_s1;
			out_unsup_q  <= unsup_s1;
			out_addr_q   <= addr_s1;
			out_data_q   <= rd_s1 ? mem_rdata : wdata_s1;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.reg_a        = out_regs_q.a;
	assign res.reg_b        = out_regs_q.b;
	assign res.reg_c        = out_regs_q.c;
	assign res.reg_d        = out_regs_q.d;
	assign res.reg_e        = out_regs_q.e;
	assign res.reg_h        = out_regs_q.h;
	assign res.reg_l        = out_regs_q.l;
	assign res.length_bytes = out_len_q;
	assign res.clock_count  = out_clocks_q;
	assign res.unsupported  = out_unsup_q;
	assign res.mem_addr     = out_addr_q;
	assign res.mem_data     = out_data_q;

`ifndef ASSERT_OFF
	// No new opcode may enter while a memory read is still merging
	a_load_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rd_s1) |-> !cmd.ready)
		else $error("opcode accepted behind a pending memory read");

	// An opcode moving out of stage 1 always lands in the result register
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("stage 1 advanced but result register is empty");

	// An unsupported result reports no length, clocks or access
	a_unsup_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_unsup_q) |->
		(out_len_q == 2'd0 && out_clocks_q == 5'd0 && out_addr_q == 16'h0000
		&& out_data_q == 8'h00))
		else $error("unsupported result carries access or timing");

	// Stage 1 stays occupied while the result register is stalled
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !res.ready) |=> valid_s1)
		else $error("stage 1 dropped an opcode under back-pressure");
`endif

endmodule
